// ===== src/fpr_pkg.sv =====
// fpr_pkg: shared constants, result record and controller/datapath command and status types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam logic [7:0] START_BYTE_RST = 8'hAA;

    // one result item
    typedef struct packed {
        logic       status;
        logic [7:0] command;
        logic [5:0] frame_length;
        logic [7:0] payload_byte;
        logic [4:0] byte_index;
        logic       last;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic cap_cmd;   // hold command byte
        logic cap_len;   // hold length byte, start sum and fill
        logic cap_data;  // store payload byte, update sum
        logic out_load;  // load the output register
        logic out_mem;   // loaded result comes from the payload store
        logic out_err;   // loaded result is a checksum mismatch
        logic rd_first;  // read payload entry zero
        logic rd_next;   // read the next payload entry
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic start_hit;   // input byte equals start byte
        logic len_over;    // input length above buffer size
        logic len_in_zero; // input length is zero
        logic fill_last;   // this payload byte is the final one
        logic sum_match;   // input byte equals running sum
        logic held_zero;   // held length is zero
        logic first_last;  // held length is one
        logic next_last;   // next read is the final entry
        logic out_free;    // output register can take a result
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== src/fpr_stream_if.sv =====
// fpr_stream_if: valid/ready channel with a typed payload
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface fpr_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/fpr_datapath.sv =====
// fpr_datapath: start byte register, header capture, checksum, payload store and output register
// depends on fpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpr_datapath import fpr_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic [7:0] i_rx_byte,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_sts         o_sts,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    output t_result         o_result
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]    r_start_byte;
    logic [7:0]    r_cmd;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_fill;
    logic [7:0]    r_sum;
    logic [CW-1:0] r_rd_idx;
    logic [7:0]    r_mem [MAX_PAYLOAD];

    logic          r_out_valid;
    logic          r_out_status;
    logic [7:0]    r_out_cmd;
    logic [5:0]    r_out_len;
    logic [7:0]    r_rd_data;
    logic [4:0]    r_out_idx;
    logic          r_out_last;

    logic [AW-1:0] rd_addr;
    logic [7:0]    len_ext;
    logic [7:0]    addr_ext;
    logic          rd_last;

    assign rd_addr  = i_cmd.rd_first ? '0 : r_rd_idx[AW-1:0];
    assign len_ext  = 8'(r_len);
    assign addr_ext = 8'(rd_addr);
    assign rd_last  = i_cmd.rd_first ? o_sts.first_last : o_sts.next_last;

    always_comb begin
        o_sts.start_hit   = (i_rx_byte == r_start_byte);
        o_sts.len_over    = (i_rx_byte > 8'(MAX_PAYLOAD));
        o_sts.len_in_zero = (i_rx_byte == 8'd0);
        o_sts.fill_last   = ((CW+1)'(r_fill) + (CW+1)'(1)) >= (CW+1)'(r_len);
        o_sts.sum_match   = (i_rx_byte == r_sum);
        o_sts.held_zero   = (r_len == '0);
        o_sts.first_last  = (r_len == CW'(1));
        o_sts.next_last   = ((CW+1)'(r_rd_idx) + (CW+1)'(1)) == (CW+1)'(r_len);
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    // header, checksum and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_cmd        <= '0;
            r_len        <= '0;
            r_fill       <= '0;
            r_sum        <= '0;
            r_rd_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_start_byte <= i_cfg_wdata;
            end
            if (i_cmd.cap_cmd) begin
                r_cmd <= i_rx_byte;
            end
            if (i_cmd.cap_len) begin
                r_len  <= i_rx_byte[CW-1:0];
                r_fill <= '0;
                r_sum  <= r_cmd + i_rx_byte;
            end
            if (i_cmd.cap_data) begin
                r_fill <= r_fill + CW'(1);
                r_sum  <= r_sum + i_rx_byte;
            end
            if (i_cmd.rd_first) begin
                r_rd_idx <= CW'(1);
            end else if (i_cmd.rd_next) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
        end
    end

    // payload store write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_data) begin
            r_mem[r_fill[AW-1:0]] <= i_rx_byte;
        end
    end

    // registered read doubles as the payload field of the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rd_data <= i_cmd.out_mem ? r_mem[rd_addr] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_err;
            r_out_cmd    <= r_cmd;
            r_out_len    <= len_ext[5:0];
            r_out_idx    <= i_cmd.out_mem ? addr_ext[4:0] : 5'd0;
            r_out_last   <= i_cmd.out_mem ? rd_last : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_result.status       = r_out_status;
    assign o_result.command      = r_out_cmd;
    assign o_result.frame_length = r_out_len;
    assign o_result.payload_byte = r_rd_data;
    assign o_result.byte_index   = r_out_idx;
    assign o_result.last         = r_out_last;

endmodule

`default_nettype wire

// ===== src/fpr_controller.sv =====
// fpr_controller: frame parse state machine, drives datapath commands and input ready
// depends on fpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpr_controller import fpr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_rx_valid,
    output logic         o_rx_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_HUNT  = 6'b000001,
        S_CMD   = 6'b000010,
        S_LEN   = 6'b000100,
        S_DATA  = 6'b001000,
        S_SUM   = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   rx_fire;

    assign rx_fire = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_rx_ready = 1'b1;
        unique case (r_state)
            S_CMD: begin
                if (rx_fire) begin
                    o_cmd.cap_cmd = 1'b1;
                    n_state       = S_LEN;
                end
            end
            S_LEN: begin
                if (rx_fire) begin
                    if (i_sts.len_over) begin
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.cap_len = 1'b1;
                        n_state       = i_sts.len_in_zero ? S_SUM : S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (rx_fire) begin
                    o_cmd.cap_data = 1'b1;
                    if (i_sts.fill_last) begin
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                o_rx_ready = i_sts.out_free;
                if (rx_fire) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_HUNT;
                    if (!i_sts.sum_match) begin
                        o_cmd.out_err = 1'b1;
                    end else if (!i_sts.held_zero) begin
                        o_cmd.out_mem  = 1'b1;
                        o_cmd.rd_first = 1'b1;
                        if (!i_sts.first_last) begin
                            n_state = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN: begin
                o_rx_ready = 1'b0;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_mem  = 1'b1;
                    o_cmd.rd_next  = 1'b1;
                    if (i_sts.next_last) begin
                        n_state = S_HUNT;
                    end
                end
            end
            default: begin
                // hunting, and any stray code behaves as hunting
                if (rx_fire) begin
                    n_state = i_sts.start_hit ? S_CMD : S_HUNT;
                end else begin
                    n_state = S_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== src/framed_packet_receiver.sv =====
// framed_packet_receiver: one byte transfer per cycle while parsing start, command, length,
// payload and, once the output register is free, checksum; first result in the cycle after
// the checksum transfer, then one per cycle while results are accepted; n payload bytes hold
// the input off while the store drains entries 1 to n-1, at a rate set by its single read port
// synchronous active-low reset: parser hunts, start byte 8'hAA, no result pending
// payload store is not cleared, entries are read only after being written
`timescale 1ns / 1ps
`default_nettype none

module framed_packet_receiver import fpr_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF   // payload store depth, 1 to 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // start byte register
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    // received bytes
    fpr_stream_if.sink      i_rx,
    // result items
    fpr_stream_if.source    o_res
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_result dp_result;
    logic    dp_out_valid;
    logic    rx_ready;

    // parse sequencing: which byte position we are at, when to drain
    fpr_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .o_rx_ready (rx_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // header registers, running checksum, payload store and output register
    fpr_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx_byte   (i_rx.data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_out_ready (o_res.ready),
        .o_out_valid (dp_out_valid),
        .o_result    (dp_result)
    );

    // input is held off during drain, and on the checksum byte while a result
    // from the previous frame still waits in the output register
    assign i_rx.ready  = rx_ready;
    assign o_res.valid = dp_out_valid;
    assign o_res.data  = dp_result;

endmodule

`default_nettype wire

// ===== src/fpr_checker.sv =====
// fpr_checker: port-level checks on the result channel of framed_packet_receiver
// depends on fpr_pkg; bound to framed_packet_receiver below
`timescale 1ns / 1ps
`default_nettype none

module fpr_checker import fpr_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_rx_ready,
    input wire logic    i_res_valid,
    input wire logic    i_res_ready,
    input wire t_result i_res_data
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("result changed while stalled");

    // input is held off while a frame is still draining
    a_drain_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_data.last |-> !i_rx_ready)
        else $error("input ready during payload drain");

    // drain runs without gaps
    a_drain_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready && !i_res_data.last |=> i_res_valid)
        else $error("gap inside a frame's results");

    // mismatch is a single result with no payload
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.status |->
            i_res_data.last && i_res_data.payload_byte == 8'd0
            && i_res_data.byte_index == 5'd0)
        else $error("malformed checksum error result");

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rx_ready  (i_rx.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);

`default_nettype wire

// ===== dv/framed_packet_receiver_checker.sv =====
`timescale 1ns / 1ps
// framed_packet_receiver_checker: watches the byte and result channels, predicts the parser
// results from the accepted bytes and compares each result field by field
// depends on fpr_pkg (result record, reset start byte, default store depth)

module framed_packet_receiver_checker import fpr_pkg::*; #(
    parameter int DEPTH = MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_rx_valid,
    input  logic       i_rx_ready,
    input  logic [7:0] i_rx_data,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  t_result    i_res_data,
    output int         o_mismatches,
    output int         o_pending,
    output int         o_results,
    output int         o_good_frames,
    output int         o_bad_frames,
    output int         o_dropped,
    output int         o_longest
);

    typedef enum logic [2:0] {
        SEEK_START,
        TAKE_CMD,
        TAKE_LEN,
        TAKE_DATA,
        TAKE_SUM
    } t_parse;

    t_parse     parse_state = SEEK_START;
    logic [7:0] start_val   = START_BYTE_RST;
    logic [7:0] cmd_q       = '0;
    logic [7:0] sum_q       = '0;
    int         len_q       = 0;
    int         fill        = 0;
    logic [7:0] store [DEPTH];

    t_result results_due [$];

    int mismatches = 0;
    int results    = 0;
    int good       = 0;
    int bad        = 0;
    int dropped    = 0;
    int longest    = 0;

    // advance the parser by one accepted byte, queue the results it releases
    task automatic parse_rx_byte(input logic [7:0] b);
        t_result r;
        int      i;
        case (parse_state)
            TAKE_CMD: begin
                cmd_q       = b;
                parse_state = TAKE_LEN;
            end
            TAKE_LEN: begin
                if (int'(b) > DEPTH) begin
                    parse_state = SEEK_START;
                    dropped++;
                end else begin
                    len_q       = int'(b);
                    fill        = 0;
                    sum_q       = cmd_q + b;
                    parse_state = (b == 8'd0) ? TAKE_SUM : TAKE_DATA;
                end
            end
            TAKE_DATA: begin
                if (fill < DEPTH) begin
                    store[fill] = b;
                end
                sum_q = sum_q + b;
                fill++;
                if (fill >= len_q) begin
                    parse_state = TAKE_SUM;
                end
            end
            TAKE_SUM: begin
                r.command      = cmd_q;
                r.frame_length = len_q[5:0];
                if (b != sum_q) begin
                    r.status       = 1'b1;
                    r.payload_byte = '0;
                    r.byte_index   = '0;
                    r.last         = 1'b1;
                    results_due.push_back(r);
                    bad++;
                end else begin
                    r.status = 1'b0;
                    if (len_q == 0) begin
                        r.payload_byte = '0;
                        r.byte_index   = '0;
                        r.last         = 1'b1;
                        results_due.push_back(r);
                    end else begin
                        for (i = 0; i < len_q && i < DEPTH; i++) begin
                            r.payload_byte = store[i];
                            r.byte_index   = i[4:0];
                            r.last         = (i + 1 == len_q);
                            results_due.push_back(r);
                        end
                    end
                    good++;
                    if (len_q > longest) begin
                        longest = len_q;
                    end
                end
                parse_state = SEEK_START;
            end
            default: begin
                parse_state = (b == start_val) ? TAKE_CMD : SEEK_START;
            end
        endcase
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        results++;
        if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result with none due", $realtime);
                $display("  actual   status %0d cmd %02h len %0d byte %02h idx %0d last %0d",
                         got.status, got.command, got.frame_length,
                         got.payload_byte, got.byte_index, got.last);
            end
        end else begin
            want = results_due.pop_front();
            if (got.status !== want.status || got.command !== want.command ||
                got.frame_length !== want.frame_length ||
                got.payload_byte !== want.payload_byte ||
                got.byte_index !== want.byte_index || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected status %0d cmd %02h len %0d byte %02h idx %0d last %0d",
                             want.status, want.command, want.frame_length,
                             want.payload_byte, want.byte_index, want.last);
                    $display("  actual   status %0d cmd %02h len %0d byte %02h idx %0d last %0d",
                             got.status, got.command, got.frame_length,
                             got.payload_byte, got.byte_index, got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_state = SEEK_START;
            start_val   = START_BYTE_RST;
            cmd_q       = '0;
            sum_q       = '0;
            len_q       = 0;
            fill        = 0;
            results_due.delete();
        end else begin
            // a result never comes from the byte taken at the same edge
            if (i_res_valid && i_res_ready) begin
                check_result(i_res_data);
            end
            // a byte taken at the write edge still sees the old start byte
            if (i_rx_valid && i_rx_ready) begin
                parse_rx_byte(i_rx_data);
            end
            if (i_cfg_we) begin
                start_val = i_cfg_wdata;
            end
        end
        o_mismatches  <= mismatches;
        o_pending     <= results_due.size();
        o_results     <= results;
        o_good_frames <= good;
        o_bad_frames  <= bad;
        o_dropped     <= dropped;
        o_longest     <= longest;
    end

endmodule

// ===== dv/framed_packet_receiver_tb.sv =====
`timescale 1ns / 1ps
// framed_packet_receiver_tb: drives framed byte streams into the receiver under several start
// byte settings with random idling on both channels, and gives the verdict
// depends on fpr_pkg, fpr_stream_if, framed_packet_receiver and framed_packet_receiver_checker

module framed_packet_receiver_tb;
    import fpr_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // cycles with no transfer before giving up
    localparam int LONG_HOLD    = 300;   // one long receiver hold-off to back up the parser
    localparam int DRAIN_CYCLES = 4;     // settle time after the last expected result

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       cfg_we      = 1'b0;
    logic [7:0] cfg_wdata   = '0;

    fpr_stream_if #(.T(logic [7:0])) rx_if ();
    fpr_stream_if #(.T(t_result))    res_if ();

    // stimulus bookkeeping
    logic [7:0] start_value   = START_BYTE_RST;  // mirrors the start byte register
    logic [7:0] payload_buf [64];
    int         items_sent    = 0;
    int         noise_sent    = 0;
    int         settings_used = 1;
    bit         idling_on     = 1'b1;

    // receiver side
    int stall_left  = 0;
    bit hold_armed  = 1'b1;
    int quiet_cycles = 0;

    // checker outputs
    int mismatches, pending, results_seen, good_frames, bad_frames, dropped, longest;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    framed_packet_receiver #(
        .MAX_PAYLOAD (MAX_PAYLOAD_DEF)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_rx        (rx_if),
        .o_res       (res_if)
    );

    framed_packet_receiver_checker #(
        .DEPTH (MAX_PAYLOAD_DEF)
    ) chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_rx_valid    (rx_if.valid),
        .i_rx_ready    (rx_if.ready),
        .i_rx_data     (rx_if.data),
        .i_res_valid   (res_if.valid),
        .i_res_ready   (res_if.ready),
        .i_res_data    (res_if.data),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_results     (results_seen),
        .o_good_frames (good_frames),
        .o_bad_frames  (bad_frames),
        .o_dropped     (dropped),
        .o_longest     (longest)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // offer one byte, return at the edge where the transfer happens
    // valid stays high on return so back-to-back bytes need no extra edge
    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 99) < 30) begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.data  <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        items_sent++;
    endtask

    // start, command, length, then keep payload bytes from payload_buf; the checksum goes
    // out only when the whole payload was sent, xored with sum_flip to corrupt it
    // an oversize length ends the frame right after the length byte
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len, input int keep,
                              input logic [7:0] sum_flip);
        logic [7:0] sum;
        int         i;
        send_rx_byte(start_value);
        send_rx_byte(cmd);
        send_rx_byte(len);
        if (int'(len) <= MAX_PAYLOAD_DEF) begin
            sum = cmd + len;
            for (i = 0; i < keep; i++) begin
                send_rx_byte(payload_buf[i]);
                sum = sum + payload_buf[i];
            end
            if (keep == int'(len)) begin
                send_rx_byte(sum ^ sum_flip);
            end
        end
    endtask

    task automatic fill_random_payload();
        int i;
        for (i = 0; i < 64; i++) begin
            payload_buf[i] = 8'($urandom);
        end
    endtask

    // stop offering, let every due result drain, then change the start byte
    task automatic write_start_byte(input logic [7:0] value);
        rx_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        // a broken frame can leave the parser mid-way with nothing due
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        start_value  = value;
        settings_used++;
    endtask

    // one start byte setting: mostly good frames with random content, plus corrupted
    // checksums, oversize lengths, cut-off frames and line noise
    task automatic run_random_phase(input logic [7:0] start_val, input bit idle_en,
                                    input int byte_goal, input bit open_with_max);
        int         first_item;
        int         kind;
        int         len;
        int         keep;
        int         n;
        logic [7:0] b;
        write_start_byte(start_val);
        idling_on <= idle_en;
        first_item = items_sent - noise_sent;
        if (open_with_max) begin
            fill_random_payload();
            send_frame(8'($urandom), 8'(MAX_PAYLOAD_DEF), MAX_PAYLOAD_DEF, 8'h00);
        end
        while (items_sent - noise_sent - first_item < byte_goal) begin
            kind = $urandom_range(0, 99);
            fill_random_payload();
            // small payloads keep the run short, a few go up to the full store
            len  = ($urandom_range(0, 4) == 0) ? $urandom_range(7, MAX_PAYLOAD_DEF)
                                                : $urandom_range(0, 6);
            if (kind < 8) begin
                // line noise while hunting, kept off the start byte
                n = $urandom_range(1, 4);
                repeat (n) begin
                    b = 8'($urandom);
                    if (b == start_value) begin
                        b = b ^ 8'h01;
                    end
                    send_rx_byte(b);
                    noise_sent++;
                end
            end else if (kind < 70) begin
                send_frame(8'($urandom), 8'(len), len, 8'h00);
            end else if (kind < 82) begin
                send_frame(8'($urandom), 8'(len), len, 8'($urandom_range(1, 255)));
            end else if (kind < 90) begin
                send_frame(8'($urandom), 8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)), 0,
                           8'h00);
            end else begin
                // cut-off frame: the next start byte lands inside its payload
                if (len == 0) begin
                    len = 1;
                end
                keep = $urandom_range(0, len - 1);
                send_frame(8'($urandom), 8'(len), keep, 8'h00);
            end
        end
    endtask

    // receiver: random stalls, stretches with none, and one long hold-off while the
    // sender keeps offering so the output backs up into the byte input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (hold_armed && results_seen >= 30) begin
            res_if.ready <= 1'b0;
            stall_left   <= LONG_HOLD;
            hold_armed   <= 1'b0;
        end else if (idling_on && $urandom_range(0, 99) < 25) begin
            res_if.ready <= 1'b0;
            stall_left   <= pick_gap() - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge i_clk) begin
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rx_if.valid = 1'b0;
        rx_if.data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset start byte
        // noise at both byte extremes, no result
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        // empty frame with a good checksum gives one result
        send_frame(8'h00, 8'd0, 0, 8'h00);
        // start byte as command and as payload is taken by position
        payload_buf[0] = start_value;
        send_frame(start_value, 8'd1, 1, 8'h00);
        // checksum mismatch on an empty frame
        send_frame(8'hFF, 8'd0, 0, 8'hFF);
        // lengths above the store size drop back to hunting
        send_frame(8'h12, 8'(MAX_PAYLOAD_DEF + 1), 0, 8'h00);
        send_frame(8'h34, 8'hFF, 0, 8'h00);
        // checksum mismatch on a frame with payload, payload at both extremes
        payload_buf[0] = 8'h00;
        payload_buf[1] = 8'hFF;
        send_frame(8'h5A, 8'd2, 2, 8'h80);

        // random part, one setting per phase, the register extremes among them
        run_random_phase(8'h00, 1'b1, 55, 1'b1);
        run_random_phase(8'hFF, 1'b1, 55, 1'b0);
        run_random_phase(8'($urandom), 1'b0, 55, 1'b0);
        run_random_phase(8'($urandom), 1'b1, 55, 1'b0);
        run_random_phase(START_BYTE_RST, 1'b1, 55, 1'b0);
        run_random_phase(8'($urandom), 1'b1, 55, 1'b1);

        // drain whatever is still due, then a short settle
        rx_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);

        $display("sent %0d bytes (%0d noise) across %0d start byte settings",
                 items_sent, noise_sent, settings_used);
        $display("%0d results checked; frames: %0d good, %0d bad checksum, %0d oversize, longest %0d",
                 results_seen, good_frames, bad_frames, dropped, longest);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== framed_packet_receiver.f =====
src/fpr_pkg.sv
src/fpr_stream_if.sv
src/fpr_datapath.sv
src/fpr_controller.sv
src/framed_packet_receiver.sv
src/fpr_checker.sv
dv/framed_packet_receiver_checker.sv
dv/framed_packet_receiver_tb.sv
